### sv/ttrd_pkg.sv
package ttrd_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int CFG_BITS       = 10;
	localparam int CFG_ADDR_BITS  = 3;
	localparam int SCALE_BITS     = 11;
	localparam int AREA_BITS      = 2 * SCALE_BITS;

	typedef struct packed {
		logic [SCALE_BITS-1:0] anchor_col;
		logic [SCALE_BITS-1:0] anchor_row;
		logic [SCALE_BITS-1:0] width;
		logic [SCALE_BITS-1:0] height;
		logic                  shape;
		logic                  from_touch;
	} cfg_t;

	typedef struct packed {
		logic rel_valid;
		logic tap;
		logic rect_in;
		logic shape;
	} rel_t;

	// floor(v * 32 / 25) through the reciprocal 41944 / 2^15
	function automatic logic [SCALE_BITS-1:0] scale_col(input logic [CFG_BITS-1:0] v);
		logic [25:0] p;
		p = 26'(v) * 26'(41944);
		return p[25:15];
	endfunction

	// floor(v * 5 / 4)
	function automatic logic [SCALE_BITS-1:0] scale_row(input logic [CFG_BITS-1:0] v);
		logic [12:0] p;
		p = 13'(v) * 13'(5);
		return p[12:2];
	endfunction

endpackage

### sv/ttrd_cfg.sv
module ttrd_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ttrd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [ttrd_pkg::CFG_BITS-1:0]      cfg_data,
	output ttrd_pkg::cfg_t                     cfg_cur,
	output ttrd_pkg::cfg_t                     cfg_nxt,
	output logic                               reload,
	output logic [ttrd_pkg::AREA_BITS-1:0]     area
);
	import ttrd_pkg::*;

	localparam logic [CFG_ADDR_BITS-1:0] REG_ANCHOR_X   = CFG_ADDR_BITS'(0);
	localparam logic [CFG_ADDR_BITS-1:0] REG_ANCHOR_Y   = CFG_ADDR_BITS'(1);
	localparam logic [CFG_ADDR_BITS-1:0] REG_WIDTH      = CFG_ADDR_BITS'(2);
	localparam logic [CFG_ADDR_BITS-1:0] REG_HEIGHT     = CFG_ADDR_BITS'(3);
	localparam logic [CFG_ADDR_BITS-1:0] REG_SHAPE      = CFG_ADDR_BITS'(4);
	localparam logic [CFG_ADDR_BITS-1:0] REG_FROM_TOUCH = CFG_ADDR_BITS'(5);

	cfg_t                 cfg_q;
	logic [AREA_BITS-1:0] area_q;

	always_comb begin
		cfg_nxt = cfg_q;
		if (cfg_we) begin
			unique case (cfg_addr)
				REG_ANCHOR_X:   cfg_nxt.anchor_col = scale_col(cfg_data);
				REG_ANCHOR_Y:   cfg_nxt.anchor_row = scale_row(cfg_data);
				REG_WIDTH:      cfg_nxt.width      = scale_col(cfg_data);
				REG_HEIGHT:     cfg_nxt.height     = scale_row(cfg_data);
				REG_SHAPE:      cfg_nxt.shape      = cfg_data[0];
				REG_FROM_TOUCH: cfg_nxt.from_touch = cfg_data[0];
				default: ;
			endcase
		end
	end

	assign reload = cfg_we && (cfg_addr == REG_ANCHOR_X || cfg_addr == REG_ANCHOR_Y ||
		cfg_addr == REG_FROM_TOUCH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q            <= '0;
			cfg_q.from_touch <= 1'b1;
			area_q           <= '0;
		end else begin
			cfg_q  <= cfg_nxt;
			area_q <= AREA_BITS'(cfg_q.width) * AREA_BITS'(cfg_q.height);
		end
	end

	assign cfg_cur = cfg_q;
	assign area    = area_q;

endmodule

### sv/ttrd_track.sv
module ttrd_track #(
	parameter int COORD_BITS = ttrd_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  evt_valid,
	input  logic [15:0]           evt_type,
	input  logic [15:0]           evt_code,
	input  logic signed [31:0]    evt_value,
	input  ttrd_pkg::cfg_t        cfg_cur,
	input  ttrd_pkg::cfg_t        cfg_nxt,
	input  logic                  reload,
	output ttrd_pkg::rel_t        rel,
	output logic [COORD_BITS-1:0] dx,
	output logic [COORD_BITS-1:0] dy
);
	import ttrd_pkg::*;

	localparam int CW = (COORD_BITS > SCALE_BITS) ? COORD_BITS : SCALE_BITS;
	localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

	localparam logic [15:0] EV_TYPE_KEY   = 16'd1;
	localparam logic [15:0] EV_TYPE_ABS   = 16'd3;
	localparam logic [15:0] EV_CODE_X     = 16'd0;
	localparam logic [15:0] EV_CODE_Y     = 16'd1;
	localparam logic [15:0] EV_CODE_TOUCH = 16'd330;

	function automatic logic [COORD_BITS-1:0] clamp_anchor(input logic [SCALE_BITS-1:0] a);
		logic [COORD_BITS-1:0] r;
		if (CW'(a) > CW'(COORD_MAX)) begin
			r = COORD_MAX;
		end else begin
			r = COORD_BITS'(a);
		end
		return r;
	endfunction

	logic [COORD_BITS-1:0] start_col_q, start_row_q, last_col_q, last_row_q;
	logic                  start_col_held_q, start_row_held_q;
	logic                  last_col_seen_q, last_row_seen_q;

	logic                  is_abs_x, is_abs_y, is_rel;
	logic [COORD_BITS-1:0] coord, col_diff, row_diff;
	logic                  col_ge, row_ge;

	assign is_abs_x = evt_type == EV_TYPE_ABS && evt_code == EV_CODE_X;
	assign is_abs_y = evt_type == EV_TYPE_ABS && evt_code == EV_CODE_Y;
	assign is_rel   = evt_type == EV_TYPE_KEY && evt_code == EV_CODE_TOUCH && evt_value == '0;

	always_comb begin
		if (evt_value[31]) begin
			coord = '0;
		end else if (|evt_value[30:COORD_BITS]) begin
			coord = COORD_MAX;
		end else begin
			coord = evt_value[COORD_BITS-1:0];
		end
	end

	assign col_ge   = last_col_q >= start_col_q;
	assign row_ge   = last_row_q >= start_row_q;
	assign col_diff = last_col_q - start_col_q;
	assign row_diff = last_row_q - start_row_q;
	assign dx       = col_ge ? col_diff : start_col_q - last_col_q;
	assign dy       = row_ge ? row_diff : start_row_q - last_row_q;

	always_comb begin
		rel.rel_valid = evt_valid && is_rel;
		rel.tap       = !(last_col_seen_q && last_row_seen_q);
		rel.rect_in   = col_ge && (CW'(col_diff) < CW'(cfg_cur.width)) &&
			row_ge && (CW'(row_diff) < CW'(cfg_cur.height));
		rel.shape     = cfg_cur.shape;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_col_q      <= '0;
			start_row_q      <= '0;
			start_col_held_q <= 1'b0;
			start_row_held_q <= 1'b0;
			last_col_q       <= '0;
			last_row_q       <= '0;
			last_col_seen_q  <= 1'b0;
			last_row_seen_q  <= 1'b0;
		end else begin
			priority if (reload) begin
				start_col_q      <= clamp_anchor(cfg_nxt.anchor_col);
				start_row_q      <= clamp_anchor(cfg_nxt.anchor_row);
				start_col_held_q <= !cfg_nxt.from_touch;
				start_row_held_q <= !cfg_nxt.from_touch;
			end else if (evt_valid && is_abs_x) begin
				if (!start_col_held_q) begin
					start_col_q      <= coord;
					start_col_held_q <= 1'b1;
				end else begin
					last_col_q      <= coord;
					last_col_seen_q <= 1'b1;
				end
			end else if (evt_valid && is_abs_y) begin
				if (!start_row_held_q) begin
					start_row_q      <= coord;
					start_row_held_q <= 1'b1;
				end else begin
					last_row_q      <= coord;
					last_row_seen_q <= 1'b1;
				end
			end else if (evt_valid && is_rel) begin
				start_col_q      <= clamp_anchor(cfg_cur.anchor_col);
				start_row_q      <= clamp_anchor(cfg_cur.anchor_row);
				start_col_held_q <= !cfg_cur.from_touch;
				start_row_held_q <= !cfg_cur.from_touch;
				last_col_q       <= '0;
				last_row_q       <= '0;
				last_col_seen_q  <= 1'b0;
				last_row_seen_q  <= 1'b0;
			end
		end
	end

endmodule

### sv/ttrd_judge.sv
module ttrd_judge #(
	parameter int COORD_BITS = ttrd_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  ttrd_pkg::rel_t                 rel,
	input  logic [COORD_BITS-1:0]          dx,
	input  logic [COORD_BITS-1:0]          dy,
	input  logic [ttrd_pkg::AREA_BITS-1:0] area,
	output logic                           out_valid,
	output logic                           clicked,
	output logic [1:0]                     click_reason
);
	import ttrd_pkg::*;

	localparam int SQW  = 2 * COORD_BITS;
	localparam int CMPW = (SQW + 1 > AREA_BITS) ? SQW + 1 : AREA_BITS;

	localparam logic [1:0] REASON_REJECT = 2'd0;
	localparam logic [1:0] REASON_TAP    = 2'd1;
	localparam logic [1:0] REASON_RECT   = 2'd2;
	localparam logic [1:0] REASON_CIRCLE = 2'd3;

	logic           valid_s2, tap_s2, rect_s2, shape_s2;
	logic [SQW-1:0] dxsq_s2, dysq_s2;
	logic           valid_q, clicked_q;
	logic [1:0]     reason_q;
	logic           circ_in;
	logic [1:0]     reason;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s2 <= rel.rel_valid;
			valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s2    <= rel.tap;
			rect_s2   <= rel.rect_in;
			shape_s2  <= rel.shape;
			dxsq_s2   <= SQW'(dx) * SQW'(dx);
			dysq_s2   <= SQW'(dy) * SQW'(dy);
			clicked_q <= reason != REASON_REJECT;
			reason_q  <= reason;
		end
	end

	assign circ_in = (CMPW'(dxsq_s2) + CMPW'(dysq_s2)) < CMPW'(area);

	always_comb begin
		priority if (tap_s2) begin
			reason = REASON_TAP;
		end else if (shape_s2) begin
			reason = circ_in ? REASON_CIRCLE : REASON_REJECT;
		end else begin
			reason = rect_s2 ? REASON_RECT : REASON_REJECT;
		end
	end

	assign out_valid    = valid_q;
	assign clicked      = clicked_q;
	assign click_reason = reason_q;

endmodule

### sv/touch_tap_region_detector.sv
// channel  direction  fields (lowest bit up)
// s        in         event_type[15:0] event_code[31:16] event_value[63:32]
// m        out        clicked[0] click_reason[2:1] zero[7:3]
// cfg      in         cfg_we, cfg_addr (register index), cfg_data[9:0]
//
// One event per clock while the output is not stalled; a release raises m_tvalid
// through the input register, the squaring stage and the result register.
// Reset clears the settings (start_from_touch set) and the gesture state.
// A stalled result freezes all stages; s_tready drops only while m_tvalid waits.
module touch_tap_region_detector #(
	parameter int COORD_BITS = ttrd_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [63:0]                        s_tdata,  // event_type, event_code, event_value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [7:0]                         m_tdata,  // clicked, click_reason, zero fill
	input  logic                               cfg_we,
	input  logic [ttrd_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [ttrd_pkg::CFG_BITS-1:0]      cfg_data
);
	import ttrd_pkg::*;

	logic                  en;
	logic                  valid_s1;
	logic [15:0]           type_s1, code_s1;
	logic signed [31:0]    value_s1;
	cfg_t                  cfg_cur, cfg_nxt;
	logic                  reload;
	logic [AREA_BITS-1:0]  area;
	rel_t                  rel;
	logic [COORD_BITS-1:0] dx, dy;
	logic                  clicked;
	logic [1:0]            click_reason;

	assign en       = !(m_tvalid && !m_tready);
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s1  <= s_tdata[15:0];
			code_s1  <= s_tdata[31:16];
			value_s1 <= s_tdata[63:32];
		end
	end

	ttrd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg_cur  (cfg_cur),
		.cfg_nxt  (cfg_nxt),
		.reload   (reload),
		.area     (area)
	);

	ttrd_track #(.COORD_BITS(COORD_BITS)) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (valid_s1 && en),
		.evt_type  (type_s1),
		.evt_code  (code_s1),
		.evt_value (value_s1),
		.cfg_cur   (cfg_cur),
		.cfg_nxt   (cfg_nxt),
		.reload    (reload),
		.rel       (rel),
		.dx        (dx),
		.dy        (dy)
	);

	ttrd_judge #(.COORD_BITS(COORD_BITS)) u_judge (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.rel          (rel),
		.dx           (dx),
		.dy           (dy),
		.area         (area),
		.out_valid    (m_tvalid),
		.clicked      (clicked),
		.click_reason (click_reason)
	);

	assign m_tdata = {5'b0, click_reason, clicked};

endmodule
